/* hdl/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the substitution table of the UTF-8 to ASCII
// transliterator.
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam int CNT_W     = 16;
    localparam int CAP_W     = 16;
    localparam int CHAR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int MAX_SUB   = 4;
    localparam int SUB_IW    = $clog2(MAX_SUB);
    localparam int SUB_LEN_W = SUB_IW + 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int CFG_IDX_W = 1;

    localparam logic [32:0]       CNT_MAX   = (33'd1 << CNT_W) - 33'd1;
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(256);

    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_QMARK = 7'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEEP_LB  = 1'b0,
        REG_CAPACITY = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             keep_lb;
        logic [CAP_W-1:0] capacity;
    } t_cfg;

    typedef struct packed {
        logic [MAX_SUB-1:0][CHAR_W-1:0] chars;
        logic [SUB_LEN_W-1:0]           len;
    } t_sub;

    // one queue entry: the characters one byte produced, plus terminator flag
    typedef struct packed {
        logic [MAX_SUB-1:0][CHAR_W-1:0] chars;
        logic [SUB_LEN_W-1:0]           n_chars;
        logic                           term;
    } t_rec;

    function automatic t_sub mk_sub(input logic [SUB_LEN_W-1:0] len,
                                    input logic [BYTE_W-1:0] a,
                                    input logic [BYTE_W-1:0] b,
                                    input logic [BYTE_W-1:0] c,
                                    input logic [BYTE_W-1:0] d);
        t_sub s;
        s.len      = len;
        s.chars[0] = a[CHAR_W-1:0];
        s.chars[1] = b[CHAR_W-1:0];
        s.chars[2] = c[CHAR_W-1:0];
        s.chars[3] = d[CHAR_W-1:0];
        return s;
    endfunction

    function automatic t_sub subst(input logic [CP_W-1:0] cp);
        t_sub s;
        case (cp)
            21'h2013:                            s = mk_sub(3'd1, "-", 8'h0, 8'h0, 8'h0);
            21'h2014:                            s = mk_sub(3'd2, "-", "-", 8'h0, 8'h0);
            21'h2018, 21'h2019, 21'h201A, 21'h201B:
                                                 s = mk_sub(3'd1, "'", 8'h0, 8'h0, 8'h0);
            21'h201C, 21'h201D, 21'h201E, 21'h201F:
                                                 s = mk_sub(3'd1, "\"", 8'h0, 8'h0, 8'h0);
            21'h2026:                            s = mk_sub(3'd3, ".", ".", ".", 8'h0);
            21'h2022, 21'h00B7, 21'h2219:        s = mk_sub(3'd1, "*", 8'h0, 8'h0, 8'h0);
            21'h2190:                            s = mk_sub(3'd2, "<", "-", 8'h0, 8'h0);
            21'h2192:                            s = mk_sub(3'd2, "-", ">", 8'h0, 8'h0);
            21'h2191:                            s = mk_sub(3'd1, "^", 8'h0, 8'h0, 8'h0);
            21'h2193, 21'h2713, 21'h2714:        s = mk_sub(3'd1, "v", 8'h0, 8'h0, 8'h0);
            21'h00A0:                            s = mk_sub(3'd1, " ", 8'h0, 8'h0, 8'h0);
            21'h00AB:                            s = mk_sub(3'd2, "<", "<", 8'h0, 8'h0);
            21'h00BB:                            s = mk_sub(3'd2, ">", ">", 8'h0, 8'h0);
            21'h2717, 21'h2718, 21'h2715, 21'h00D7:
                                                 s = mk_sub(3'd1, "x", 8'h0, 8'h0, 8'h0);
            21'h00A9:                            s = mk_sub(3'd3, "(", "c", ")", 8'h0);
            21'h00AE:                            s = mk_sub(3'd3, "(", "R", ")", 8'h0);
            21'h2122:                            s = mk_sub(3'd4, "(", "T", "M", ")");
            21'h00B0:                            s = mk_sub(3'd3, "d", "e", "g", 8'h0);
            21'h00B1:                            s = mk_sub(3'd3, "+", "/", "-", 8'h0);
            21'h00F7:                            s = mk_sub(3'd1, "/", 8'h0, 8'h0, 8'h0);
            default:                             s = mk_sub(3'd1, "?", 8'h0, 8'h0, 8'h0);
        endcase
        return s;
    endfunction

endpackage

/* hdl/u2a_ifs.sv */
// ----------------------------------------------------------------------------
// u2a_ifs
// Valid/ready channel interfaces: byte input, character output, config write.
// ----------------------------------------------------------------------------
interface u2a_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u2a_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2a_char_if;
    logic                         valid;
    logic                         ready;
    logic [u2a_pkg::CHAR_W-1:0]   out_char;
    logic                         is_terminator;
    logic                         last_of_run;

    modport source (output valid, output out_char, output is_terminator,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input is_terminator,
                    input last_of_run, output ready);
endinterface

interface u2a_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [u2a_pkg::CFG_IDX_W-1:0]  index;
    logic [u2a_pkg::CAP_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/u2a_front.sv */
// ----------------------------------------------------------------------------
// u2a_front
// UTF-8 decode state, classification of each byte and capacity limiting.
// Produces one queue entry per byte that yields characters or a terminator.
// ----------------------------------------------------------------------------
module u2a_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  u2a_pkg::t_cfg              i_cfg,
    input  logic                       i_accept,
    input  logic [u2a_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_push,
    output u2a_pkg::t_rec              o_rec
);
    import u2a_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] ch;
    } t_chr;

    function automatic t_chr ascii_map(input logic [CHAR_W-1:0] v, input logic keep);
        t_chr r;
        r.ok = 1'b1;
        r.ch = v;
        if (keep && (v == CH_LF || v == CH_CR)) begin
            r.ch = v;
        end else if (v == CH_LF || v == CH_CR || v == CH_TAB) begin
            r.ch = CH_SPACE;
        end else if (v < CH_SPACE) begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    logic [CP_W-1:0]                r_pend, n_pend;
    logic [1:0]                     r_rem, n_rem;
    logic [CNT_W-1:0]               r_cnt, n_cnt;

    logic                           cont;
    logic [CP_W-1:0]                cp_next;
    t_chr                           lead_ch;
    logic [1:0]                     lead_rem;
    logic [CP_W-1:0]                lead_pend;
    t_chr                           cp_ch;
    t_sub                           sub;
    logic [MAX_SUB-1:0][CHAR_W-1:0] raw_chars;
    logic [SUB_LEN_W-1:0]           raw_n;
    logic                           term;
    logic [CAP_W-1:0]               cap_m1;
    logic [CNT_W-1:0]               lim;
    logic [CNT_W-1:0]               room;
    logic [SUB_LEN_W-1:0]           n_emit;

    assign cont    = (i_byte[7:6] == 2'b10);
    assign cp_next = {r_pend[CP_W-7:0], i_byte[5:0]};

    // lead byte classification
    always_comb begin
        lead_ch   = '{ok: 1'b1, ch: CH_QMARK};
        lead_rem  = 2'd0;
        lead_pend = '0;
        if (!i_byte[7]) begin
            lead_ch = ascii_map(i_byte[CHAR_W-1:0], i_cfg.keep_lb);
        end else if (i_byte[7:5] == 3'b110) begin
            lead_ch.ok = 1'b0;
            lead_rem   = 2'd1;
            lead_pend  = CP_W'(i_byte[4:0]);
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_ch.ok = 1'b0;
            lead_rem   = 2'd2;
            lead_pend  = CP_W'(i_byte[3:0]);
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_ch.ok = 1'b0;
            lead_rem   = 2'd3;
            lead_pend  = CP_W'(i_byte[2:0]);
        end
    end

    // completed code point
    always_comb begin
        cp_ch = ascii_map(cp_next[CHAR_W-1:0], i_cfg.keep_lb);
        if (cp_next < CP_W'(8'h80)) begin
            sub          = '0;
            sub.chars[0] = cp_ch.ch;
            sub.len      = cp_ch.ok ? SUB_LEN_W'(1) : SUB_LEN_W'(0);
        end else begin
            sub = subst(cp_next);
        end
    end

    always_comb begin
        raw_chars = '0;
        raw_n     = '0;
        term      = 1'b0;
        n_pend    = r_pend;
        n_rem     = r_rem;
        if (i_byte == '0) begin
            if (r_rem != 2'd0) begin
                raw_chars[0] = CH_QMARK;
                raw_n        = SUB_LEN_W'(1);
            end
            term   = 1'b1;
            n_pend = '0;
            n_rem  = 2'd0;
        end else if (r_rem != 2'd0 && cont) begin
            n_pend = cp_next;
            n_rem  = r_rem - 2'd1;
            if (r_rem == 2'd1) begin
                raw_chars = sub.chars;
                raw_n     = sub.len;
                n_pend    = '0;
            end
        end else if (r_rem != 2'd0) begin
            raw_chars[0] = CH_QMARK;
            raw_chars[1] = lead_ch.ch;
            raw_n        = lead_ch.ok ? SUB_LEN_W'(2) : SUB_LEN_W'(1);
            n_pend       = lead_pend;
            n_rem        = lead_rem;
        end else begin
            raw_chars[0] = lead_ch.ch;
            raw_n        = lead_ch.ok ? SUB_LEN_W'(1) : SUB_LEN_W'(0);
            n_pend       = lead_pend;
            n_rem        = lead_rem;
        end
    end

    // capacity limit
    always_comb begin
        cap_m1 = (i_cfg.capacity == '0) ? '0 : i_cfg.capacity - CAP_W'(1);
        lim    = (33'(cap_m1) > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(cap_m1);
        room   = lim - r_cnt;
        if (lim <= r_cnt) begin
            n_emit = '0;
        end else if (room >= CNT_W'(raw_n)) begin
            n_emit = raw_n;
        end else begin
            n_emit = room[SUB_LEN_W-1:0];
        end
        n_cnt = term ? '0 : r_cnt + CNT_W'(n_emit);
    end

    assign o_push        = i_accept && (n_emit != '0 || term);
    assign o_rec.chars   = raw_chars;
    assign o_rec.n_chars = n_emit;
    assign o_rec.term    = term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_rem  <= 2'd0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_rem  <= n_rem;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* hdl/u2a_queue.sv */
// ----------------------------------------------------------------------------
// u2a_queue
// Short FIFO of per-byte entries between the decoder and the serializer.
// ----------------------------------------------------------------------------
module u2a_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u2a_pkg::t_rec i_wdata,
    input  logic          i_pop,
    output u2a_pkg::t_rec o_rdata,
    output logic          o_full,
    output logic          o_empty
);
    import u2a_pkg::*;

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + Q_AW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hdl/u2a_back.sv */
// ----------------------------------------------------------------------------
// u2a_back
// Serializes queue entries into one character per cycle while the receiver is
// ready, through an output register; marks the terminator and the last character of each byte.
// ----------------------------------------------------------------------------
module u2a_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  u2a_pkg::t_rec              i_head,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic [u2a_pkg::CHAR_W-1:0] o_char,
    output logic                       o_term,
    output logic                       o_last
);
    import u2a_pkg::*;

    logic [SUB_LEN_W-1:0] r_idx;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_term;
    logic                 r_last;

    logic [SUB_LEN_W-1:0] total;
    logic                 is_last;
    logic                 is_char;
    logic                 load;

    assign total   = i_head.n_chars + SUB_LEN_W'(i_head.term);
    assign is_last = (r_idx == total - SUB_LEN_W'(1));
    assign is_char = (r_idx < i_head.n_chars);
    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + SUB_LEN_W'(1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= is_char ? i_head.chars[r_idx[SUB_IW-1:0]] : CH_NUL;
            r_term <= !is_char;
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_term  = r_term;
    assign o_last  = r_last;

endmodule

/* hdl/utf8_to_ascii_transliterator.sv */
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// UTF-8 byte stream in, printable ASCII characters out.
//
// i_in takes one UTF-8 byte per item; a zero byte ends the string and
// yields a terminator item (out_char 0, is_terminator 1). o_out gives one
// character per item; last_of_run marks the final item caused by a byte.
// i_cfg writes keep_line_breaks (index 0) and output_capacity (index 1); it
// is always ready and the user must write it only while the block is idle;
// the block does not enforce this. The decoder takes one byte per cycle while
// the queue is not full; the output side gives one character per cycle while
// the receiver is ready, and a byte that expands to more than one character
// holds its queue entry until all of them are out. A 4-entry queue between
// the two absorbs expansion; the decoder stalls (i_in.ready low) only when
// it is full. A stalled receiver holds o_out and backs up into the queue,
// then into i_in. Reset clears the decode state, the queue and the output
// register and restores keep_line_breaks = 0, output_capacity = 256.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2a_byte_if.sink    i_in,
    u2a_char_if.source  o_out,
    u2a_cfg_if.sink     i_cfg
);
    import u2a_pkg::*;

    logic             r_keep_lb;
    logic [CAP_W-1:0] r_capacity;
    t_cfg             cfg;
    logic             in_accept;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_rec             q_wdata;
    t_rec             q_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_lb  <= 1'b0;
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_KEEP_LB:  r_keep_lb  <= i_cfg.data[0];
                REG_CAPACITY: r_capacity <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    assign cfg.keep_lb  = r_keep_lb;
    assign cfg.capacity = r_capacity;

    assign i_in.ready = !q_full;
    assign in_accept  = i_in.valid && !q_full;

    u2a_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .o_push   (q_push),
        .o_rec    (q_wdata)
    );

    u2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u2a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_rdata),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_char  (o_out.out_char),
        .o_term  (o_out.is_terminator),
        .o_last  (o_out.last_of_run)
    );

    a_term_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_terminator |-> o_out.last_of_run && o_out.out_char == CH_NUL)
        else $error("terminator without last_of_run or with nonzero char");

    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_terminator |->
            o_out.out_char >= CH_SPACE || o_out.out_char == CH_LF || o_out.out_char == CH_CR)
        else $error("control character emitted");

    a_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.in_byte == '0 |=> !q_empty)
        else $error("end of string did not queue a terminator");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

endmodule

/* test/u2a_output_check.sv */
// ----------------------------------------------------------------------------
// u2a_output_check
// Watches the byte, character and register-write channels of the UTF-8 to
// ASCII transliterator, works out the characters each accepted byte must
// produce and compares every accepted character item against them in order.
// ----------------------------------------------------------------------------
module u2a_output_check (
    input  logic i_clk,
    input  logic i_rst_n,
    u2a_byte_if  i_byte,
    u2a_char_if  i_char,
    u2a_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import u2a_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              term;
        logic              last;
    } t_char_res;

    logic             keep_breaks;
    logic [CAP_W-1:0] capacity;
    logic [CP_W-1:0]  code_acc;
    logic [1:0]       cont_left;
    logic [CNT_W-1:0] n_written;
    t_char_res        expected_chars[$];
    t_char_res        byte_chars[$];
    int               n_fail = 0;

    function automatic string sub_text(input logic [CP_W-1:0] cp);
        case (cp)
            21'h2013:                               return "-";
            21'h2014:                               return "--";
            21'h2018, 21'h2019, 21'h201A, 21'h201B: return "'";
            21'h201C, 21'h201D, 21'h201E, 21'h201F: return "\"";
            21'h2026:                               return "...";
            21'h2022, 21'h00B7, 21'h2219:           return "*";
            21'h2190:                               return "<-";
            21'h2192:                               return "->";
            21'h2191:                               return "^";
            21'h2193, 21'h2713, 21'h2714:           return "v";
            21'h00A0:                               return " ";
            21'h00AB:                               return "<<";
            21'h00BB:                               return ">>";
            21'h2717, 21'h2718, 21'h2715, 21'h00D7: return "x";
            21'h00A9:                               return "(c)";
            21'h00AE:                               return "(R)";
            21'h2122:                               return "(TM)";
            21'h00B0:                               return "deg";
            21'h00B1:                               return "+/-";
            21'h00F7:                               return "/";
            default:                                return "";
        endcase
    endfunction

    // emits one character unless the string buffer is full or the byte already has MAX_SUB characters
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        logic [32:0] limit;
        limit = (capacity == '0) ? 33'd0 : 33'(capacity) - 33'd1;
        if (limit > CNT_MAX) begin
            limit = CNT_MAX;
        end
        if (33'(n_written) < limit && byte_chars.size() < MAX_SUB) begin
            byte_chars.push_back(t_char_res'{ch, 1'b0, 1'b0});
            n_written = n_written + 1'b1;
        end
    endtask

    task automatic put_ascii(input logic [CHAR_W-1:0] v);
        if (keep_breaks && (v == CH_LF || v == CH_CR)) begin
            put_char(v);
        end else if (v == CH_LF || v == CH_CR || v == CH_TAB) begin
            put_char(CH_SPACE);
        end else if (v >= CH_SPACE) begin
            put_char(v);
        end
    endtask

    task automatic put_code(input logic [CP_W-1:0] cp);
        string s;
        s = sub_text(cp);
        if (cp < 21'h80) begin
            put_ascii(cp[CHAR_W-1:0]);
        end else if (s.len() == 0) begin
            put_char(CH_QMARK);
        end else begin
            for (int k = 0; k < s.len(); k++) begin
                put_char(CHAR_W'(s[k]));
            end
        end
    endtask

    task automatic take_lead(input logic [BYTE_W-1:0] b);
        if (b < 8'h80) begin
            put_ascii(b[CHAR_W-1:0]);
        end else if (b[7:5] == 3'b110) begin
            code_acc  = CP_W'(b[4:0]);
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            code_acc  = CP_W'(b[3:0]);
            cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            code_acc  = CP_W'(b[2:0]);
            cont_left = 2'd3;
        end else begin
            put_char(CH_QMARK);
        end
    endtask

    task automatic transliterate_byte(input logic [BYTE_W-1:0] b);
        byte_chars.delete();
        if (b == 8'h00) begin
            if (cont_left != 2'd0) begin
                put_char(CH_QMARK);
            end
            byte_chars.push_back(t_char_res'{CH_NUL, 1'b1, 1'b0});
            code_acc  = '0;
            cont_left = '0;
            n_written = '0;
        end else if (cont_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                code_acc  = {code_acc[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    put_code(code_acc);
                    code_acc = '0;
                end
            end else begin
                // broken sequence: flag it, then retry the byte as a lead
                put_char(CH_QMARK);
                code_acc  = '0;
                cont_left = '0;
                take_lead(b);
            end
        end else begin
            take_lead(b);
        end
        if (byte_chars.size() > 0) begin
            byte_chars[byte_chars.size() - 1].last = 1'b1;
        end
        foreach (byte_chars[k]) begin
            expected_chars.push_back(byte_chars[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_char_res want;
        if (!i_rst_n) begin
            keep_breaks = 1'b0;
            capacity    = CAP_RESET;
            code_acc    = '0;
            cont_left   = '0;
            n_written   = '0;
            expected_chars.delete();
        end else begin
            if (i_char.valid && i_char.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected item: out_char %0h is_terminator %0b last_of_run %0b",
                           i_char.out_char, i_char.is_terminator, i_char.last_of_run);
                    n_fail++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_char.out_char !== want.ch) begin
                        $error("out_char: expected %0h, actual %0h", want.ch, i_char.out_char);
                        n_fail++;
                    end
                    if (i_char.is_terminator !== want.term) begin
                        $error("is_terminator: expected %0b, actual %0b",
                               want.term, i_char.is_terminator);
                        n_fail++;
                    end
                    if (i_char.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, i_char.last_of_run);
                        n_fail++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_KEEP_LB) begin
                    keep_breaks = i_cfg.data[0];
                end else if (i_cfg.index == REG_CAPACITY) begin
                    capacity = i_cfg.data;
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                transliterate_byte(i_byte.in_byte);
            end
        end
        o_pending    = expected_chars.size();
        o_fail_count = n_fail;
    end

endmodule

/* test/tb_utf8_to_ascii_transliterator.sv */
// ----------------------------------------------------------------------------
// tb_utf8_to_ascii_transliterator
// Drives UTF-8 byte streams into the transliterator: a directed opening
// (ASCII boundaries, control characters, bad and broken sequences, overlong forms,
// substitutions, end of string), then random strings of well-formed and
// malformed sequences under several register settings, with random gaps on
// the byte side and random stalls on the character side.
// ----------------------------------------------------------------------------
module tb_utf8_to_ascii_transliterator;
    timeunit 1ns;
    timeprecision 1ps;
    import u2a_pkg::*;

    localparam int LAT_WAIT = 10;

    localparam logic [CP_W-1:0] MAPPED_CPS [33] = '{
        21'h2013, 21'h2014, 21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h201C,
        21'h201D, 21'h201E, 21'h201F, 21'h2026, 21'h2022, 21'h00B7, 21'h2219,
        21'h2190, 21'h2192, 21'h2191, 21'h2193, 21'h00A0, 21'h00AB, 21'h00BB,
        21'h2713, 21'h2714, 21'h2717, 21'h2718, 21'h2715, 21'h00A9, 21'h00AE,
        21'h2122, 21'h00B0, 21'h00B1, 21'h00D7, 21'h00F7
    };

    localparam logic [BYTE_W-1:0] OPENING [26] = '{
        8'h41, 8'h7F, 8'h09, 8'h0A, 8'h01, 8'h80, 8'hFF, 8'hF8,
        8'hC2, 8'hA9,
        8'hE2, 8'h84, 8'hA2,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hC1, 8'h81,
        8'hC0, 8'h80,
        8'hE2, 8'h41,
        8'hC3, 8'h00,
        8'h00
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   calm_items = 0;
    int   n_bytes_sent = 0;

    u2a_byte_if byte_ch();
    u2a_char_if char_ch();
    u2a_cfg_if  cfg_ch();

    utf8_to_ascii_transliterator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch),
        .i_cfg   (cfg_ch)
    );

    u2a_output_check u_output_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_char       (char_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver stalls: mostly short, a few long, with long stall-free stretches
    initial begin
        int   r;
        int   len;
        logic v;
        char_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                v   = 1'b1;
                len = $urandom_range(1, 8);
            end else if (r < 60) begin
                v   = 1'b1;
                len = $urandom_range(30, 120);
            end else if (r < 90) begin
                v   = 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                v   = 1'b0;
                len = $urandom_range(10, 40);
            end
            char_ch.ready <= v;
            repeat (len) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_items > 0) begin
            calm_items--;
            return 0;
        end
        if (r < 4) begin
            calm_items = $urandom_range(20, 50);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic int natural_len(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        n_bytes_sent++;
    endtask

    // encodes cp in n_len bytes (overlong allowed), sends the first n_send
    task automatic send_utf8(input logic [CP_W-1:0] cp, input int n_len, input int n_send);
        logic [BYTE_W-1:0] seq [4];
        case (n_len)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < n_send; k++) begin
            send_byte(seq[k]);
        end
    endtask

    task automatic send_token();
        int                r;
        int                len;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 2))
                    0:       b = 8'h09;
                    1:       b = 8'h0A;
                    default: b = 8'h0D;
                endcase
            end else begin
                b = BYTE_W'($urandom_range(1, 127));
            end
            send_byte(b);
        end else if (r < 43) begin
            cp = MAPPED_CPS[$urandom_range(0, 32)];
            send_utf8(cp, natural_len(cp), natural_len(cp));
        end else if (r < 58) begin
            len = $urandom_range(2, 4);
            case (len)
                2:       cp = CP_W'($urandom_range(32'h80, 32'h7FF));
                3:       cp = CP_W'($urandom_range(32'h800, 32'hFFFF));
                default: cp = CP_W'($urandom_range(32'h10000, 32'h1FFFFF));
            endcase
            send_utf8(cp, len, len);
        end else if (r < 65) begin
            // overlong forms of ASCII values, NUL included
            cp  = CP_W'($urandom_range(0, 127));
            len = $urandom_range(2, 4);
            send_utf8(cp, len, len);
        end else if (r < 73) begin
            // truncated sequence; a following token that is not a continuation byte breaks it
            cp  = CP_W'($urandom_range(0, 32'h1FFFFF));
            len = $urandom_range(2, 4);
            send_utf8(cp, len, $urandom_range(1, len - 1));
        end else if (r < 80) begin
            if ($urandom_range(0, 1) == 0) begin
                b = BYTE_W'($urandom_range(8'h80, 8'hBF));
            end else begin
                b = BYTE_W'($urandom_range(8'hF8, 8'hFF));
            end
            send_byte(b);
        end else if (r < 88) begin
            send_byte(BYTE_W'($urandom_range(1, 255)));
        end else begin
            send_byte(8'h00);
        end
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CAP_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic keep, input logic [CAP_W-1:0] cap);
        drain();
        write_reg(REG_KEEP_LB, CAP_W'(keep));
        write_reg(REG_CAPACITY, cap);
    endtask

    initial begin
        int               target;
        int               r;
        logic             keep;
        logic [CAP_W-1:0] cap;

        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_KEEP_LB;
        cfg_ch.data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[k]) begin
            send_byte(OPENING[k]);
        end

        // line breaks kept, widest buffer
        set_mode(1'b1, 16'hFFFF);
        send_byte(8'h0D);
        send_byte(8'h0A);
        send_byte(8'h09);
        send_utf8(21'h00B1, 2, 2);
        send_byte(8'h00);

        // no room for characters, only terminators
        set_mode(1'b0, 16'd1);
        send_utf8(21'h2122, 3, 3);
        send_byte(8'h41);
        send_byte(8'h00);

        // substitution cut short by the buffer
        set_mode(1'b0, 16'd3);
        send_utf8(21'h2122, 3, 3);
        send_byte(8'h00);

        for (int phase = 0; phase < 10; phase++) begin
            r    = $urandom_range(0, 99);
            keep = 1'($urandom_range(0, 1));
            if (phase == 0) begin
                keep = 1'b1;
                cap  = 16'hFFFF;
            end else if (phase == 1) begin
                keep = 1'b0;
                cap  = 16'd1;
            end else if (r < 15) begin
                cap = CAP_W'($urandom_range(1, 2));
            end else if (r < 50) begin
                cap = CAP_W'($urandom_range(3, 12));
            end else if (r < 70) begin
                cap = CAP_W'($urandom_range(13, 40));
            end else if (r < 80) begin
                cap = 16'd256;
            end else if (r < 90) begin
                cap = 16'hFFFF;
            end else begin
                cap = CAP_W'($urandom_range(1, 65535));
            end
            set_mode(keep, cap);
            target = n_bytes_sent + 15;
            while (n_bytes_sent < target) begin
                send_token();
            end
        end

        drain();
        @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* utf8_to_ascii_transliterator.f */
hdl/u2a_pkg.sv
hdl/u2a_ifs.sv
hdl/u2a_front.sv
hdl/u2a_queue.sv
hdl/u2a_back.sv
hdl/utf8_to_ascii_transliterator.sv
test/u2a_output_check.sv
test/tb_utf8_to_ascii_transliterator.sv
